// ----- rtl/bdpa_pkg.sv -----
// Types, widths and flit field helpers of the deflection port allocator.
// No dependencies; used by every other file of the block.
package bdpa_pkg;
   localparam int FLIT_W    = 56;
   localparam int OUT_W     = 57;
   localparam int NUM_IN    = 4;
   localparam int NUM_CAND  = 5;
   localparam int RANK_W    = 3;
   localparam int MAX_PORTS = 7;
   localparam int AGE_W     = 31;
   localparam int DEFL_BIT  = 56;

   typedef logic [FLIT_W-1:0] flit_type;
   typedef logic [OUT_W-1:0]  oflit_type;

   typedef struct packed {
      logic [RANK_W-1:0]    rank;
      logic [MAX_PORTS-1:0] prod;
   } lane_info_type;

   function automatic logic [AGE_W-1:0] age_of(input flit_type f);
      return f[31:1];
   endfunction

   function automatic logic signed [7:0] delta_of(input flit_type f, input int pos);
      return $signed(f[pos +: 8]);
   endfunction
endpackage

// ----- rtl/bdpa_if.sv -----
// Request and response channel interfaces of the deflection port allocator.
// Depends on bdpa_pkg.
interface bdpa_req_if;
   logic               valid;
   logic               ready;
   bdpa_pkg::flit_type flit_in_1;
   bdpa_pkg::flit_type flit_in_2;
   bdpa_pkg::flit_type flit_in_3;
   bdpa_pkg::flit_type flit_in_4;
   bdpa_pkg::flit_type flit_in_local;
   modport source (output valid, flit_in_1, flit_in_2, flit_in_3, flit_in_4, flit_in_local,
                   input ready);
   modport sink (input valid, flit_in_1, flit_in_2, flit_in_3, flit_in_4, flit_in_local,
                 output ready);
endinterface

interface bdpa_rsp_if;
   logic                valid;
   logic                ready;
   bdpa_pkg::oflit_type out_xplus;
   bdpa_pkg::oflit_type out_xminus;
   bdpa_pkg::oflit_type out_yplus;
   bdpa_pkg::oflit_type out_yminus;
   bdpa_pkg::flit_type  out_eject;
   logic                inject_stop;
   logic                inject_overflow;
   logic                no_port_error;
   modport source (output valid, out_xplus, out_xminus, out_yplus, out_yminus, out_eject,
                   inject_stop, inject_overflow, no_port_error, input ready);
   modport sink (input valid, out_xplus, out_xminus, out_yplus, out_yminus, out_eject,
                 inject_stop, inject_overflow, no_port_error, output ready);
endinterface

// ----- rtl/bdpa_fifo.sv -----
// Injection FIFO with same-beat bypass of the local flit to the head.
// Depends on bdpa_pkg.
module bdpa_fifo #(
   parameter int DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  bdpa_pkg::flit_type loc,
   input  logic               join_ok,
   output logic               head_join,
   output bdpa_pkg::flit_type head,
   output logic               overflow,
   output logic               stop
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bdpa_pkg::flit_type mem_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in, count_w;
   logic             wr;

   function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] i);
      return (32'(i) + 1 >= DEPTH) ? '0 : i + PTR_W'(1);
   endfunction

   always_comb begin
      wr        = loc[0] && (count_ff < CNT_W'(DEPTH));
      overflow  = loc[0] && (count_ff >= CNT_W'(DEPTH));
      count_w   = count_ff + CNT_W'(wr);
      head_join = join_ok && (count_w != '0);
      head      = (count_ff == '0) ? loc : mem_ff[head_ff];
      tail_in   = wr ? next_idx(tail_ff) : tail_ff;
      head_in   = head_join ? next_idx(head_ff) : head_ff;
      count_in  = count_w - CNT_W'(head_join);
      stop      = (count_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (advance) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && wr) begin
         mem_ff[tail_ff] <= loc;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("fifo count above depth");
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      overflow |-> !wr) else $error("write on full fifo");
   a_stop_cnt: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((count_ff != '0) == $past(stop))) else $error("stop flag mismatch");
`endif
endmodule

// ----- rtl/bdpa_lane.sv -----
// One candidate lane: age rank among all candidates and productive port mask.
// Depends on bdpa_pkg.
module bdpa_lane #(
   parameter int MESH_PORTS = 4,
   parameter int LANE_IDX   = 0
) (
   input  bdpa_pkg::flit_type           flits [bdpa_pkg::NUM_CAND],
   input  logic [bdpa_pkg::NUM_CAND-1:0] valid,
   output bdpa_pkg::lane_info_type      info
);
   logic signed [7:0] dx, dy, dz;
   logic [bdpa_pkg::MAX_PORTS-1:0] dir;
   logic unit;

   always_comb begin
      info.rank = '0;
      for (int j = 0; j < bdpa_pkg::NUM_CAND; j++) begin
         if (valid[j] && ((bdpa_pkg::age_of(flits[j]) < bdpa_pkg::age_of(flits[LANE_IDX]))
             || (bdpa_pkg::age_of(flits[j]) == bdpa_pkg::age_of(flits[LANE_IDX])
                 && j < LANE_IDX))) begin
            info.rank = info.rank + bdpa_pkg::RANK_W'(1);
         end
      end
      dx = bdpa_pkg::delta_of(flits[LANE_IDX], 32);
      dy = bdpa_pkg::delta_of(flits[LANE_IDX], 40);
      dz = bdpa_pkg::delta_of(flits[LANE_IDX], 48);
      unit = (dx == 8'sd1 || dx == -8'sd1) && (dy == 8'sd1 || dy == -8'sd1)
          && (dz == 8'sd1 || dz == -8'sd1);
      dir = {1'b0, dz < -8'sd1, dz > 8'sd1, dy < -8'sd1, dy > 8'sd1, dx < -8'sd1, dx > 8'sd1};
      for (int p = 0; p < bdpa_pkg::MAX_PORTS; p++) begin
         info.prod[p] = (p < MESH_PORTS) ? dir[p] : ((p == MESH_PORTS) ? unit : 1'b0);
      end
   end
endmodule

// ----- rtl/bdpa_merge.sv -----
// Merging stage: walks candidates in age rank order and assigns output ports.
// Depends on bdpa_pkg.
module bdpa_merge #(
   parameter int MESH_PORTS = 4
) (
   input  bdpa_pkg::flit_type            flits [bdpa_pkg::NUM_CAND],
   input  logic [bdpa_pkg::NUM_CAND-1:0] valid,
   input  bdpa_pkg::lane_info_type       info  [bdpa_pkg::NUM_CAND],
   output bdpa_pkg::oflit_type           res   [MESH_PORTS+1],
   output logic                          err
);
   logic [MESH_PORTS:0]            busy;
   logic                           found, done;
   bdpa_pkg::flit_type             sel;
   logic [bdpa_pkg::MAX_PORTS-1:0] pm;

   always_comb begin
      busy = '0;
      err  = 1'b0;
      found = 1'b0;
      done = 1'b0;
      sel  = '0;
      pm   = '0;
      for (int p = 0; p <= MESH_PORTS; p++) res[p] = '0;
      for (int r = 0; r < bdpa_pkg::NUM_CAND; r++) begin
         found = 1'b0;
         sel   = '0;
         pm    = '0;
         for (int i = 0; i < bdpa_pkg::NUM_CAND; i++) begin
            if (valid[i] && info[i].rank == bdpa_pkg::RANK_W'(r)) begin
               found = 1'b1;
               sel   = flits[i];
               pm    = info[i].prod;
            end
         end
         done = !found;
         for (int p = 0; p <= MESH_PORTS; p++) begin
            if (!done && !busy[p] && pm[p]) begin
               busy[p] = 1'b1;
               res[p]  = {1'b0, sel};
               done    = 1'b1;
            end
         end
         for (int p = 0; p < MESH_PORTS; p++) begin
            if (!done && !busy[p]) begin
               busy[p] = 1'b1;
               res[p]  = {1'b1, sel};
               done    = 1'b1;
            end
         end
         if (!done) err = 1'b1;
      end
   end
endmodule

// ----- rtl/bless_deflection_port_allocator_core.sv -----
// Top level of the deflection port allocator: FIFO, five lanes, merge, output register.
// Depends on bdpa_pkg, bdpa_if, bdpa_fifo, bdpa_lane, bdpa_merge.
//
// Usage:
//   req carries one router cycle per beat: four arriving flits and an
//   optional local flit for the injection FIFO (bit 0 marks a flit present).
//   rsp carries one beat per request beat: the flit on each mesh port (bit 56
//   set when deflected), the ejected flit and the stop, overflow and error
//   flags.
//   A request beat accepted at an edge is loaded into the output register at
//   that edge and shown on rsp from there. Throughput is one beat per cycle
//   while rsp is not stalled; the lanes rank and classify all five candidates in
//   parallel and the merge stage allocates ports in age order within the same cycle.
//   req.ready is high when the output register is empty or is being taken,
//   so a stalled rsp holds its beat and stops further requests only then.
//   Reset empties the injection FIFO and the output register.
module bless_deflection_port_allocator_core #(
   parameter int INJ_FIFO_DEPTH = 8,
   parameter int MESH_PORTS     = 4
) (
   input  logic       clock,
   input  logic       reset,
   bdpa_req_if.sink   req,
   bdpa_rsp_if.source rsp
);
   localparam int NC = bdpa_pkg::NUM_CAND;

   bdpa_pkg::flit_type      flits [NC];
   logic [NC-1:0]           valid;
   bdpa_pkg::lane_info_type info  [NC];
   bdpa_pkg::oflit_type     res   [MESH_PORTS+1];
   bdpa_pkg::flit_type      head;
   logic                    head_join, overflow, stop, err, accept, join_ok;
   logic [2:0]              arrivals;

   logic                rsp_valid_ff;
   bdpa_pkg::oflit_type xp_ff, xm_ff, yp_ff, ym_ff;
   bdpa_pkg::flit_type  ej_ff;
   logic                stop_ff, ovf_ff, err_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      flits[0] = req.flit_in_1;
      flits[1] = req.flit_in_2;
      flits[2] = req.flit_in_3;
      flits[3] = req.flit_in_4;
      flits[4] = head;
      valid    = {head_join, req.flit_in_4[0], req.flit_in_3[0], req.flit_in_2[0],
                  req.flit_in_1[0]};
      arrivals = 3'(req.flit_in_1[0]) + 3'(req.flit_in_2[0]) + 3'(req.flit_in_3[0])
               + 3'(req.flit_in_4[0]);
      join_ok  = 32'(arrivals) < MESH_PORTS;
   end

   bdpa_fifo #(.DEPTH(INJ_FIFO_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .advance(accept), .loc(req.flit_in_local),
      .join_ok(join_ok), .head_join(head_join), .head(head), .overflow(overflow),
      .stop(stop)
   );

   for (genvar g = 0; g < NC; g++) begin : g_lane
      bdpa_lane #(.MESH_PORTS(MESH_PORTS), .LANE_IDX(g)) u_lane (
         .flits(flits), .valid(valid), .info(info[g])
      );
   end

   bdpa_merge #(.MESH_PORTS(MESH_PORTS)) u_merge (
      .flits(flits), .valid(valid), .info(info), .res(res), .err(err)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         xp_ff   <= res[0];
         xm_ff   <= res[1];
         yp_ff   <= res[2];
         ym_ff   <= res[3];
         ej_ff   <= res[MESH_PORTS][bdpa_pkg::FLIT_W-1:0];
         stop_ff <= stop;
         ovf_ff  <= overflow;
         err_ff  <= err;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.out_xplus       = xp_ff;
   assign rsp.out_xminus      = xm_ff;
   assign rsp.out_yplus       = yp_ff;
   assign rsp.out_yminus      = ym_ff;
   assign rsp.out_eject       = ej_ff;
   assign rsp.inject_stop     = stop_ff;
   assign rsp.inject_overflow = ovf_ff;
   assign rsp.no_port_error   = err_ff;

`ifndef SYNTH
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff) else $error("accepted beat not registered");
   a_defl_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(xp_ff[bdpa_pkg::DEFL_BIT] && !xp_ff[0])
                    && !(ym_ff[bdpa_pkg::DEFL_BIT] && !ym_ff[0]))
      else $error("deflect mark on empty port");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> $stable(xp_ff) && $stable(err_ff))
      else $error("stalled output changed");
`endif
endmodule

// ----- tb/bless_deflection_port_allocator_core_tb.sv -----
// Testbench of the deflection port allocator: directed and random router cycles,
// predicted in place and checked beat by beat. Depends on bdpa_pkg, bdpa_if and the core.
`timescale 1ns / 1ps
module bless_deflection_port_allocator_core_tb;

   localparam int FIFO_DEPTH = 8;
   localparam int PORT_XP    = 0;
   localparam int PORT_XM    = 1;
   localparam int PORT_YP    = 2;
   localparam int PORT_YM    = 3;
   localparam int PORT_EJECT = 4;

   typedef struct {
      bdpa_pkg::flit_type arr[4];
      bdpa_pkg::flit_type loc;
   } cycle_in_type;

   typedef struct {
      bdpa_pkg::oflit_type mesh[4];
      bdpa_pkg::flit_type  eject;
      logic                stop;
      logic                ovf;
      logic                err;
   } cycle_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdpa_req_if req();
   bdpa_rsp_if rsp();

   bless_deflection_port_allocator_core i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always #2 clock = ~clock;

   cycle_out_type      alloc_q[$];
   bdpa_pkg::flit_type inj_mem[FIFO_DEPTH];
   int                 inj_rd = 0;
   int                 inj_wr = 0;
   int                 inj_cnt = 0;
   int                 errors = 0;
   bit                 rx_idle_en = 1'b0;
   int                 rx_hold = 0;
   int                 rx_left = 0;

   function automatic bit goes_toward(bdpa_pkg::flit_type f, int p);
      logic signed [7:0] dx, dy, dz;
      dx = $signed(f[39:32]);
      dy = $signed(f[47:40]);
      dz = $signed(f[55:48]);
      case (p)
         PORT_XP: return dx > 1;
         PORT_XM: return dx < -1;
         PORT_YP: return dy > 1;
         PORT_YM: return dy < -1;
         PORT_EJECT:
            return (dx == 1 || dx == -1) && (dy == 1 || dy == -1) && (dz == 1 || dz == -1);
         default: return 0;
      endcase
   endfunction

   function automatic cycle_out_type allocate_ports(cycle_in_type c);
      bdpa_pkg::flit_type cand[5];
      bdpa_pkg::flit_type v;
      bdpa_pkg::flit_type res[5];
      bit                 busy[5];
      bit                 done;
      int                 nc, arrivals, j;
      cycle_out_type      o;
      nc = 0;
      o.ovf = 0;
      o.err = 0;
      foreach (o.mesh[p]) o.mesh[p] = '0;
      for (int i = 0; i < 4; i++)
         if (c.arr[i][0]) begin
            cand[nc] = c.arr[i];
            nc++;
         end
      arrivals = nc;
      if (c.loc[0]) begin
         if (inj_cnt >= FIFO_DEPTH) begin
            o.ovf = 1;
         end else begin
            inj_mem[inj_wr] = c.loc;
            inj_wr = (inj_wr + 1) % FIFO_DEPTH;
            inj_cnt++;
         end
      end
      if (arrivals < 4 && inj_cnt != 0) begin
         cand[nc] = inj_mem[inj_rd];
         nc++;
         inj_rd = (inj_rd + 1) % FIFO_DEPTH;
         inj_cnt--;
      end
      for (int i = 1; i < nc; i++) begin
         v = cand[i];
         j = i;
         while (j > 0 && cand[j-1][31:1] > v[31:1]) begin
            cand[j] = cand[j-1];
            j--;
         end
         cand[j] = v;
      end
      for (int p = 0; p < 5; p++) begin
         busy[p] = 0;
         res[p] = '0;
      end
      for (int i = 0; i < nc; i++) begin
         done = 0;
         for (int p = 0; p < 5 && !done; p++)
            if (!busy[p] && goes_toward(cand[i], p)) begin
               busy[p] = 1;
               res[p] = cand[i];
               done = 1;
            end
         for (int p = 0; p < 4 && !done; p++)
            if (!busy[p]) begin
               busy[p] = 1;
               res[p] = cand[i];
               o.mesh[p] = {1'b1, cand[i]};
               done = 1;
            end
         if (!done) o.err = 1;
      end
      for (int p = 0; p < 4; p++)
         if (!(busy[p] && o.mesh[p][56] && o.mesh[p][55:0] == res[p]))
            o.mesh[p] = {1'b0, res[p]};
      o.eject = res[PORT_EJECT];
      o.stop = inj_cnt != 0;
      return o;
   endfunction

   function automatic bdpa_pkg::flit_type make_flit(int age, int dx, int dy, int dz);
      logic [30:0] a;
      a = age[30:0];
      return {dz[7:0], dy[7:0], dx[7:0], a, 1'b1};
   endfunction

   function automatic int pick_delta();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return -128;
         1: return 127;
         2: return -1;
         3: return 1;
         4: return 0;
         5: return 2;
         6: return -2;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic bdpa_pkg::flit_type rand_flit(int pct_valid);
      bdpa_pkg::flit_type f;
      int                 age;
      if ($urandom_range(0, 99) >= pct_valid) begin
         f = bdpa_pkg::flit_type'({$urandom, $urandom});
         f[0] = 1'b0;
         return f;
      end
      age = ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 15);
      return make_flit(age, pick_delta(), pick_delta(), pick_delta());
   endfunction

   function automatic bdpa_pkg::flit_type unit_flit(int age);
      return make_flit(age, $urandom_range(0, 1) ? 1 : -1, $urandom_range(0, 1) ? 1 : -1,
                       $urandom_range(0, 1) ? 1 : -1);
   endfunction

   task automatic send_cycle(cycle_in_type c, int gap);
      bit acc;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.flit_in_1     <= c.arr[0];
      req.flit_in_2     <= c.arr[1];
      req.flit_in_3     <= c.arr[2];
      req.flit_in_4     <= c.arr[3];
      req.flit_in_local <= c.loc;
      do begin
         @(negedge clock);
         acc = req.ready;
         if (acc) alloc_q.push_back(allocate_ports(c));
         @(posedge clock);
      end while (!acc);
   endtask

   function automatic int rand_gap();
      if ($urandom_range(0, 2) != 0) return 0;
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   task automatic drain();
      req.valid <= 1'b0;
      while (alloc_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic test_directed();
      cycle_in_type c;
      c.arr = '{make_flit(0, 127, 0, 0), make_flit(32'h7FFF_FFFF, -128, 0, 0),
                make_flit(5, 0, 127, 0), make_flit(5, 0, -128, 0)};
      c.loc = '0;
      send_cycle(c, 0);
      // all four want x plus: oldest wins, ties by port, rest deflected
      c.arr = '{make_flit(3, 5, 0, 0), make_flit(3, 5, 0, 0),
                make_flit(1, 5, 0, 0), make_flit(9, 5, 0, 0)};
      send_cycle(c, 0);
      // same-cycle injection joins at once; the arriving flit ejects, the injected one is deflected
      c.arr = '{make_flit(4, 1, 1, 1), '0, '0, '0};
      c.loc = make_flit(4, -1, -1, -1);
      send_cycle(c, 0);
      // invalid flits with garbage bits
      c.arr = '{56'hFF_FFFF_FFFF_FFFE, 56'hAA_AAAA_AAAA_AAAA, 56'h55_5555_5555_5554, '0};
      c.loc = 56'hFF_FFFF_FFFF_FFFE;
      send_cycle(c, 1);
      // full arrivals block injection; fill FIFO then overflow
      for (int i = 0; i < 11; i++) begin
         c.arr = '{make_flit(i, 2, 0, 0), make_flit(i, -2, 0, 0),
                   make_flit(i, 0, 2, 0), make_flit(i, 0, -2, 0)};
         c.loc = unit_flit(i);
         send_cycle(c, 0);
      end
      c.arr = '{'0, '0, '0, '0};
      c.loc = '0;
      for (int i = 0; i < 9; i++) send_cycle(c, 0);
      drain();
   endtask

   task automatic test_backpressure();
      cycle_in_type c;
      rx_hold = 80;
      for (int i = 0; i < 20; i++) begin
         foreach (c.arr[k]) c.arr[k] = rand_flit(70);
         c.loc = rand_flit(60);
         send_cycle(c, 0);
      end
      drain();
   endtask

   task automatic test_random(int n);
      cycle_in_type c;
      int           burst;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) rx_idle_en = 1'b0;
         if (i == n / 2 + 100) rx_idle_en = 1'b1;
         if (i == n / 3) drain();
         burst = $urandom_range(0, 3);
         foreach (c.arr[k]) c.arr[k] = rand_flit(burst == 0 ? 95 : 55);
         c.loc = rand_flit(burst == 1 ? 90 : 40);
         send_cycle(c, rx_idle_en ? rand_gap() : 0);
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp.ready <= 1'b0;
      end else if (rx_left > 0) begin
         rx_left <= rx_left - 1;
         rsp.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
         rx_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(negedge clock) begin
      cycle_out_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (alloc_q.size() == 0) begin
            $display("%0t: unexpected beat on rsp", $time);
            errors++;
         end else begin
            e = alloc_q.pop_front();
            if (rsp.out_xplus !== e.mesh[PORT_XP]) begin
               $display("%0t: out_xplus exp %h got %h", $time, e.mesh[PORT_XP], rsp.out_xplus);
               errors++;
            end
            if (rsp.out_xminus !== e.mesh[PORT_XM]) begin
               $display("%0t: out_xminus exp %h got %h", $time, e.mesh[PORT_XM], rsp.out_xminus);
               errors++;
            end
            if (rsp.out_yplus !== e.mesh[PORT_YP]) begin
               $display("%0t: out_yplus exp %h got %h", $time, e.mesh[PORT_YP], rsp.out_yplus);
               errors++;
            end
            if (rsp.out_yminus !== e.mesh[PORT_YM]) begin
               $display("%0t: out_yminus exp %h got %h", $time, e.mesh[PORT_YM], rsp.out_yminus);
               errors++;
            end
            if (rsp.out_eject !== e.eject) begin
               $display("%0t: out_eject exp %h got %h", $time, e.eject, rsp.out_eject);
               errors++;
            end
            if (rsp.inject_stop !== e.stop) begin
               $display("%0t: inject_stop exp %b got %b", $time, e.stop, rsp.inject_stop);
               errors++;
            end
            if (rsp.inject_overflow !== e.ovf) begin
               $display("%0t: inject_overflow exp %b got %b", $time, e.ovf, rsp.inject_overflow);
               errors++;
            end
            if (rsp.no_port_error !== e.err) begin
               $display("%0t: no_port_error exp %b got %b", $time, e.err, rsp.no_port_error);
               errors++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("bless_deflection_port_allocator_core_tb failed");
      $finish;
   end

   initial begin
      req.valid         <= 1'b0;
      req.flit_in_1     <= '0;
      req.flit_in_2     <= '0;
      req.flit_in_3     <= '0;
      req.flit_in_4     <= '0;
      req.flit_in_local <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      rx_idle_en = 1'b1;
      test_backpressure();
      test_random(860);
      if (errors == 0 && alloc_q.size() == 0)
         $display("bless_deflection_port_allocator_core_tb passed");
      else
         $display("bless_deflection_port_allocator_core_tb failed");
      $finish;
   end
endmodule
